FILE: rtl/jmh_pkg.sv
// jmh_pkg: shared types and constants for the message header parser
// used by jmh_decode, jmh_out_reg and jpip_message_header_parser_top
`default_nettype none

package jmh_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_BITS   = 32;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [OUT_BITS-1:0]   t_out_value;

    // header field being parsed
    typedef enum logic [2:0] {
        PH_BIN_FIRST = 3'd0,
        PH_BIN_CONT  = 3'd1,
        PH_CLASS     = 3'd2,
        PH_CSN       = 3'd3,
        PH_OFFSET    = 3'd4,
        PH_LENGTH    = 3'd5,
        PH_AUX       = 3'd6
    } t_phase;

    // indicator codes from bits 6..5 of the first bin-id byte
    localparam logic [1:0] IND_FORBIDDEN = 2'd0;
    localparam logic [1:0] IND_CLASS     = 2'd2;
    localparam logic [1:0] IND_CLASS_CSN = 2'd3;

    typedef struct packed {
        logic class_here;
        logic csn_here;
        logic completes;
        logic forbid;
    } t_flags;

    typedef struct packed {
        t_out_value bin_number;
        t_out_value msg_class;
        t_out_value stream_index;
        t_out_value bin_offset;
        t_out_value body_len;
        t_out_value aux_value;
        logic       aux_present;
        logic       completes_bin;
        logic       forbidden;
    } t_result;

    // shift one 7-bit group into a value, wrapping to the value width
    function automatic t_value shift_in(input t_value v, input logic [7:0] b);
        shift_in = t_value'({v, b[6:0]});
    endfunction

    function automatic t_out_value to_out(input t_value v);
        to_out = t_out_value'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/jmh_decode.sv
// jmh_decode: header field state and per-byte decode logic
// depends on jmh_pkg
`default_nettype none

module jmh_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_out_free,
    output logic                 o_advance,
    output logic                 o_emit,
    output jmh_pkg::t_result     o_result
);

    jmh_pkg::t_phase r_phase, n_phase;
    jmh_pkg::t_value r_acc, n_acc;
    jmh_pkg::t_value r_bin_number, n_bin_number;
    jmh_pkg::t_value r_msg_class, n_msg_class;
    jmh_pkg::t_value r_stream_index, n_stream_index;
    jmh_pkg::t_value r_offset, n_offset;
    jmh_pkg::t_value r_length, n_length;
    jmh_pkg::t_value r_aux, n_aux;
    jmh_pkg::t_flags r_flags, n_flags;

    logic            more;
    logic            emit_c;
    logic            aux_here;
    logic [1:0]      ind;
    jmh_pkg::t_value acc_shift;

    assign more      = i_byte[7];
    assign ind       = i_byte[6:5];
    assign acc_shift = jmh_pkg::shift_in(r_acc, i_byte);

    // next-state logic
    always_comb begin
        n_phase        = r_phase;
        n_acc          = acc_shift;
        n_bin_number   = r_bin_number;
        n_msg_class    = r_msg_class;
        n_stream_index = r_stream_index;
        n_offset       = r_offset;
        n_length       = r_length;
        n_aux          = r_aux;
        n_flags        = r_flags;
        unique case (r_phase)
            jmh_pkg::PH_BIN_CONT: begin
                if (!more) begin
                    n_bin_number = acc_shift;
                    n_acc        = '0;
                    if (r_flags.class_here) begin
                        n_phase = jmh_pkg::PH_CLASS;
                    end else if (r_flags.csn_here) begin
                        n_phase = jmh_pkg::PH_CSN;
                    end else begin
                        n_phase = jmh_pkg::PH_OFFSET;
                    end
                end
            end
            jmh_pkg::PH_CLASS: begin
                if (!more) begin
                    n_msg_class = acc_shift;
                    n_acc       = '0;
                    n_phase     = r_flags.csn_here ? jmh_pkg::PH_CSN : jmh_pkg::PH_OFFSET;
                end
            end
            jmh_pkg::PH_CSN: begin
                if (!more) begin
                    n_stream_index = acc_shift;
                    n_acc          = '0;
                    n_phase        = jmh_pkg::PH_OFFSET;
                end
            end
            jmh_pkg::PH_OFFSET: begin
                if (!more) begin
                    n_offset = acc_shift;
                    n_acc    = '0;
                    n_phase  = jmh_pkg::PH_LENGTH;
                end
            end
            jmh_pkg::PH_LENGTH: begin
                if (!more) begin
                    n_length = acc_shift;
                    n_acc    = '0;
                    // odd class means an aux field follows
                    if (r_msg_class[0]) begin
                        n_phase = jmh_pkg::PH_AUX;
                    end else begin
                        n_phase = jmh_pkg::PH_BIN_FIRST;
                    end
                end
            end
            jmh_pkg::PH_AUX: begin
                if (!more) begin
                    n_aux   = acc_shift;
                    n_acc   = '0;
                    n_phase = jmh_pkg::PH_BIN_FIRST;
                end
            end
            default: begin
                // first bin-id byte, also taken for the unused phase code
                n_flags.forbid     = (ind == jmh_pkg::IND_FORBIDDEN);
                n_flags.class_here = (ind == jmh_pkg::IND_CLASS) ||
                                     (ind == jmh_pkg::IND_CLASS_CSN);
                n_flags.csn_here   = (ind == jmh_pkg::IND_CLASS_CSN);
                n_flags.completes  = i_byte[4];
                n_offset           = '0;
                n_length           = '0;
                n_acc              = jmh_pkg::t_value'(i_byte[3:0]);
                if (more) begin
                    n_phase = jmh_pkg::PH_BIN_CONT;
                end else begin
                    n_bin_number = jmh_pkg::t_value'(i_byte[3:0]);
                    n_acc        = '0;
                    if (n_flags.class_here) begin
                        n_phase = jmh_pkg::PH_CLASS;
                    end else if (n_flags.csn_here) begin
                        n_phase = jmh_pkg::PH_CSN;
                    end else begin
                        n_phase = jmh_pkg::PH_OFFSET;
                    end
                end
            end
        endcase
    end

    // output logic: the last byte of length (when the class is even) or of aux ends a header
    always_comb begin
        unique case (r_phase)
            jmh_pkg::PH_LENGTH: begin
                emit_c   = !more && !r_msg_class[0];
                aux_here = 1'b0;
            end
            jmh_pkg::PH_AUX: begin
                emit_c   = !more;
                aux_here = !more;
            end
            default: begin
                emit_c   = 1'b0;
                aux_here = 1'b0;
            end
        endcase
    end

    // a byte that completes a header waits until the result register is free
    assign o_advance = i_valid && (!emit_c || i_out_free);
    assign o_emit    = o_advance && emit_c;

    always_comb begin
        o_result.bin_number    = jmh_pkg::to_out(n_bin_number);
        o_result.msg_class     = jmh_pkg::to_out(n_msg_class);
        o_result.stream_index  = jmh_pkg::to_out(n_stream_index);
        o_result.bin_offset    = jmh_pkg::to_out(n_offset);
        o_result.body_len      = jmh_pkg::to_out(n_length);
        o_result.aux_value     = jmh_pkg::to_out(n_aux);
        o_result.aux_present   = aux_here;
        o_result.completes_bin = n_flags.completes;
        o_result.forbidden     = n_flags.forbid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= jmh_pkg::PH_BIN_FIRST;
            r_acc          <= '0;
            r_bin_number   <= '0;
            r_msg_class    <= '0;
            r_stream_index <= '0;
            r_offset       <= '0;
            r_length       <= '0;
            r_aux          <= '0;
            r_flags        <= '0;
        end else if (o_advance) begin
            r_phase        <= n_phase;
            r_acc          <= n_acc;
            r_bin_number   <= n_bin_number;
            r_msg_class    <= n_msg_class;
            r_stream_index <= n_stream_index;
            r_offset       <= n_offset;
            r_length       <= n_length;
            r_aux          <= n_aux;
            r_flags        <= n_flags;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jmh_out_reg.sv
// jmh_out_reg: result register holding one decoded header for the consumer
// depends on jmh_pkg
`default_nettype none

module jmh_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire jmh_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output jmh_pkg::t_result      o_result
);

    logic             r_valid;
    jmh_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jpip_message_header_parser_top.sv
// jpip_message_header_parser_top: byte-wide message header parser, top level
// depends on jmh_pkg, jmh_decode and jmh_out_reg
`default_nettype none

// Decodes JPP/JPT stream message headers one byte per transaction. Each
// header is a run of VBAS fields (bin-id, optional class, optional codestream
// number, offset, length, aux when the class is odd); one result transaction
// comes out on the byte that ends a header. Class and codestream number carry
// over from the previous header when omitted. Throughput is one byte per
// clock while no completing byte waits: each byte goes through an input
// register, then a single shift-and-or field update into the parse state,
// and a completed header is latched into a result register. A result is
// valid once its last byte has left the input register and been decoded.
// A completing byte waits in the input register, and the input stalls, only
// while the result register still holds an untaken result.
module jpip_message_header_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_bin_number,
    output logic [31:0]      o_msg_class,
    output logic [31:0]      o_stream_index,
    output logic [31:0]      o_bin_offset,
    output logic [31:0]      o_body_len,
    output logic [31:0]      o_aux_value,
    output logic             o_aux_present,
    output logic             o_completes_bin,
    output logic             o_forbidden
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             advance;
    logic             emit;
    logic             out_free;
    jmh_pkg::t_result dec_result;
    jmh_pkg::t_result out_result;

    assign o_ready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    jmh_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_byte     (r_in_byte),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_emit     (emit),
        .o_result   (dec_result)
    );

    jmh_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (dec_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_bin_number    = out_result.bin_number;
    assign o_msg_class     = out_result.msg_class;
    assign o_stream_index  = out_result.stream_index;
    assign o_bin_offset    = out_result.bin_offset;
    assign o_body_len      = out_result.body_len;
    assign o_aux_value     = out_result.aux_value;
    assign o_aux_present   = out_result.aux_present;
    assign o_completes_bin = out_result.completes_bin;
    assign o_forbidden     = out_result.forbidden;

endmodule

`default_nettype wire

FILE: test/jmh_checker.sv
// jmh_checker: predicts message header parser results from the accepted byte stream
// and compares them field by field with the result channel; depends on jmh_pkg
`default_nettype none

module jmh_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_byte_valid,
    input  wire logic             i_byte_ready,
    input  wire logic [7:0]       i_header_byte,
    input  wire logic             i_result_valid,
    input  wire logic             i_result_ready,
    input  wire jmh_pkg::t_result i_result,
    output int                    o_mismatches,
    output int                    o_pending
);

    jmh_pkg::t_phase  parse_phase;
    jmh_pkg::t_value  field_acc;
    jmh_pkg::t_value  bin_id;
    jmh_pkg::t_value  class_in_force;
    jmh_pkg::t_value  stream_in_force;
    jmh_pkg::t_value  offset_val;
    jmh_pkg::t_value  length_val;
    jmh_pkg::t_value  last_aux;
    jmh_pkg::t_flags  hdr_flags;
    jmh_pkg::t_result expected_headers[$];
    jmh_pkg::t_result oldest_header;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic queue_header(input logic aux_here);
        jmh_pkg::t_result hdr;
        hdr.bin_number    = jmh_pkg::t_out_value'(bin_id);
        hdr.msg_class     = jmh_pkg::t_out_value'(class_in_force);
        hdr.stream_index  = jmh_pkg::t_out_value'(stream_in_force);
        hdr.bin_offset    = jmh_pkg::t_out_value'(offset_val);
        hdr.body_len      = jmh_pkg::t_out_value'(length_val);
        hdr.aux_value     = jmh_pkg::t_out_value'(last_aux);
        hdr.aux_present   = aux_here;
        hdr.completes_bin = hdr_flags.completes;
        hdr.forbidden     = hdr_flags.forbid;
        expected_headers.push_back(hdr);
        parse_phase = jmh_pkg::PH_BIN_FIRST;
        field_acc   = '0;
    endtask

    // optional class and codestream fields follow the bin id when flagged
    task automatic begin_after_bin();
        field_acc = '0;
        if (hdr_flags.class_here)
            parse_phase = jmh_pkg::PH_CLASS;
        else if (hdr_flags.csn_here)
            parse_phase = jmh_pkg::PH_CSN;
        else
            parse_phase = jmh_pkg::PH_OFFSET;
    endtask

    task automatic parse_header_byte(input logic [7:0] b);
        logic            more;
        logic [1:0]      ind;
        jmh_pkg::t_value shifted;
        more    = b[7];
        ind     = b[6:5];
        shifted = (field_acc << 7) | jmh_pkg::t_value'(b[6:0]);
        case (parse_phase)
            jmh_pkg::PH_BIN_CONT: begin
                field_acc = shifted;
                if (!more) begin
                    bin_id = shifted;
                    begin_after_bin();
                end
            end
            jmh_pkg::PH_CLASS: begin
                field_acc = shifted;
                if (!more) begin
                    class_in_force = shifted;
                    field_acc      = '0;
                    parse_phase    = hdr_flags.csn_here ? jmh_pkg::PH_CSN
                                                        : jmh_pkg::PH_OFFSET;
                end
            end
            jmh_pkg::PH_CSN: begin
                field_acc = shifted;
                if (!more) begin
                    stream_in_force = shifted;
                    field_acc       = '0;
                    parse_phase     = jmh_pkg::PH_OFFSET;
                end
            end
            jmh_pkg::PH_OFFSET: begin
                field_acc = shifted;
                if (!more) begin
                    offset_val  = shifted;
                    field_acc   = '0;
                    parse_phase = jmh_pkg::PH_LENGTH;
                end
            end
            jmh_pkg::PH_LENGTH: begin
                field_acc = shifted;
                if (!more) begin
                    length_val = shifted;
                    field_acc  = '0;
                    // an odd class in force means an aux field follows
                    if (class_in_force[0])
                        parse_phase = jmh_pkg::PH_AUX;
                    else
                        queue_header(1'b0);
                end
            end
            jmh_pkg::PH_AUX: begin
                field_acc = shifted;
                if (!more) begin
                    last_aux = shifted;
                    queue_header(1'b1);
                end
            end
            default: begin
                // first bin id byte; the forbidden indicator reads no optional field
                hdr_flags.forbid     = (ind == jmh_pkg::IND_FORBIDDEN);
                hdr_flags.class_here = (ind == jmh_pkg::IND_CLASS) ||
                                       (ind == jmh_pkg::IND_CLASS_CSN);
                hdr_flags.csn_here   = (ind == jmh_pkg::IND_CLASS_CSN);
                hdr_flags.completes  = b[4];
                offset_val = '0;
                length_val = '0;
                field_acc  = jmh_pkg::t_value'(b[3:0]);
                if (more) begin
                    parse_phase = jmh_pkg::PH_BIN_CONT;
                end else begin
                    bin_id = field_acc;
                    begin_after_bin();
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase     = jmh_pkg::PH_BIN_FIRST;
            field_acc       = '0;
            bin_id          = '0;
            class_in_force  = '0;
            stream_in_force = '0;
            offset_val      = '0;
            length_val      = '0;
            last_aux        = '0;
            hdr_flags       = '0;
            expected_headers.delete();
            o_mismatches    = 0;
        end else begin
            // a result is registered only after its last byte is accepted, so check first
            if (i_result_valid && i_result_ready) begin
                if (expected_headers.size() == 0) begin
                    report_mismatch("result with no header expected", i_result.bin_number, '0);
                end else begin
                    oldest_header = expected_headers.pop_front();
                    if (i_result.bin_number !== oldest_header.bin_number)
                        report_mismatch("bin_number", i_result.bin_number,
                                        oldest_header.bin_number);
                    if (i_result.msg_class !== oldest_header.msg_class)
                        report_mismatch("msg_class", i_result.msg_class,
                                        oldest_header.msg_class);
                    if (i_result.stream_index !== oldest_header.stream_index)
                        report_mismatch("stream_index", i_result.stream_index,
                                        oldest_header.stream_index);
                    if (i_result.bin_offset !== oldest_header.bin_offset)
                        report_mismatch("bin_offset", i_result.bin_offset,
                                        oldest_header.bin_offset);
                    if (i_result.body_len !== oldest_header.body_len)
                        report_mismatch("body_len", i_result.body_len,
                                        oldest_header.body_len);
                    if (i_result.aux_value !== oldest_header.aux_value)
                        report_mismatch("aux_value", i_result.aux_value, oldest_header.aux_value);
                    if (i_result.aux_present !== oldest_header.aux_present)
                        report_mismatch("aux_present", 32'(i_result.aux_present),
                                        32'(oldest_header.aux_present));
                    if (i_result.completes_bin !== oldest_header.completes_bin)
                        report_mismatch("completes_bin", 32'(i_result.completes_bin),
                                        32'(oldest_header.completes_bin));
                    if (i_result.forbidden !== oldest_header.forbidden)
                        report_mismatch("forbidden", 32'(i_result.forbidden),
                                        32'(oldest_header.forbidden));
                end
            end
            if (i_byte_valid && i_byte_ready)
                parse_header_byte(i_header_byte);
        end
        o_pending = expected_headers.size();
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: drives header byte streams into jpip_message_header_parser_top and gives the verdict
// depends on jmh_pkg, the parser RTL and jmh_checker
`default_nettype none

module tb_top;

    localparam int RANDOM_BYTES = 1750;

    // bin-only header; full header with odd class and aux; forbidden indicator with
    // carried odd class, wrapping length and zero aux; long bin id with even class
    localparam logic [7:0] DIRECTED_HEADERS [26] = '{
        8'h20, 8'h00, 8'h00,
        8'h7f, 8'h01, 8'h7f, 8'hff, 8'h7f, 8'h7f, 8'h05,
        8'h1f, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h80, 8'h00,
        8'hcf, 8'hff, 8'h7f, 8'h02, 8'h00, 8'h03
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    logic [7:0]  header_byte  = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] res_bin_number;
    logic [31:0] res_msg_class;
    logic [31:0] res_stream_index;
    logic [31:0] res_bin_offset;
    logic [31:0] res_body_len;
    logic [31:0] res_aux_value;
    logic        res_aux_present;
    logic        res_completes_bin;
    logic        res_forbidden;
    int          mismatches;
    int          pending_headers;

    logic [7:0]  header_bytes[$];
    int          burst_left    = 0;
    logic        gen_class_odd = 1'b0;

    jpip_message_header_parser_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_ready         (byte_ready),
        .i_data_byte     (header_byte),
        .o_valid         (result_valid),
        .i_ready         (result_ready),
        .o_bin_number    (res_bin_number),
        .o_msg_class     (res_msg_class),
        .o_stream_index  (res_stream_index),
        .o_bin_offset    (res_bin_offset),
        .o_body_len      (res_body_len),
        .o_aux_value     (res_aux_value),
        .o_aux_present   (res_aux_present),
        .o_completes_bin (res_completes_bin),
        .o_forbidden     (res_forbidden)
    );

    jmh_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_byte_valid   (byte_valid),
        .i_byte_ready   (byte_ready),
        .i_header_byte  (header_byte),
        .i_result_valid (result_valid),
        .i_result_ready (result_ready),
        .i_result       ({res_bin_number, res_msg_class, res_stream_index, res_bin_offset,
                          res_body_len, res_aux_value, res_aux_present, res_completes_bin,
                          res_forbidden}),
        .o_mismatches   (mismatches),
        .o_pending      (pending_headers)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // mostly one-byte fields, now and then long ones that wrap the value width
    function automatic int field_len();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 9)
            return 1;
        else if (pick < 13)
            return 2;
        else if (pick < 15)
            return $urandom_range(3, 5);
        return $urandom_range(6, 7);
    endfunction

    task automatic add_field(input int n_bytes, output logic [7:0] last_b);
        logic [7:0] b;
        last_b = 8'h00;
        for (int k = 0; k < n_bytes; k++) begin
            b    = {1'b0, 7'($urandom)};
            b[7] = (k != n_bytes - 1);
            header_bytes.push_back(b);
            last_b = b;
        end
    endtask

    task automatic add_header();
        logic [1:0] ind;
        logic [7:0] last_b;
        int         bin_len;
        ind     = 2'($urandom);
        bin_len = field_len();
        header_bytes.push_back({bin_len > 1, ind, 5'($urandom)});
        add_field(bin_len - 1, last_b);
        if (ind == jmh_pkg::IND_CLASS || ind == jmh_pkg::IND_CLASS_CSN) begin
            add_field(field_len(), last_b);
            // class parity is the low bit of its last group
            gen_class_odd = last_b[0];
        end
        if (ind == jmh_pkg::IND_CLASS_CSN)
            add_field(field_len(), last_b);
        add_field(field_len(), last_b);
        add_field(field_len(), last_b);
        if (gen_class_odd)
            add_field(field_len(), last_b);
    endtask

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic offer_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        byte_valid  <= 1'b1;
        header_byte <= b;
        do @(negedge clk); while (!byte_ready);
        @(posedge clk);
    endtask

    task automatic send_queued();
        while (header_bytes.size() != 0)
            offer_byte(header_bytes.pop_front());
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (pending_headers != 0);
        @(posedge clk);
    endtask

    initial begin
        int   random_sent;
        int   drain_cycles;
        logic mid_pause_done;
        random_sent    = 0;
        mid_pause_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_HEADERS[k])
            header_bytes.push_back(DIRECTED_HEADERS[k]);
        send_queued();
        byte_valid <= 1'b0;
        wait_drained();
        gen_class_odd = 1'b0;

        while (random_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 85)
                add_header();
            else
                repeat ($urandom_range(1, 8)) header_bytes.push_back(8'($urandom));
            random_sent += header_bytes.size();
            send_queued();
            if (!mid_pause_done && random_sent >= RANDOM_BYTES / 2) begin
                byte_valid <= 1'b0;
                wait_drained();
                mid_pause_done = 1'b1;
            end
        end
        byte_valid <= 1'b0;

        drain_cycles = 0;
        while (pending_headers != 0 && drain_cycles < 5000) begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_headers == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side: a long hold-off early on so the parser backs up, then random stalls
    initial begin
        int mode;
        wait (rst_n);
        @(posedge clk);
        result_ready <= 1'b1;
        repeat (6) @(posedge clk);
        result_ready <= 1'b0;
        repeat (240) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 15);
            if (mode == 0) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(100, 250)) @(posedge clk);
            end else if (mode < 6) begin
                result_ready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end else begin
                repeat ($urandom_range(5, 30)) begin
                    result_ready <= ($urandom_range(0, 2) != 0);
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
